[rtl/lodd_pkg.sv]
// Shared types and constants of the lock order deadlock detector.
// Used by lodd_scan and lock_order_deadlock_detector_unit.
package lodd_pkg;

	localparam int unsigned NUM_LOCKS_DEF   = 32;
	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned ID_W            = 5;
	localparam int unsigned STATUS_W        = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DEADLOCK = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOT_TOP  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		TS_IDLE,
		TS_RD_TOP,
		TS_RD_EDGE,
		TS_SCAN,
		TS_DONE
	} top_state_t;

	typedef enum logic [2:0] {
		SS_IDLE,
		SS_ROOT,
		SS_LOAD,
		SS_WALK,
		SS_POP,
		SS_DONE
	} scan_state_t;

	typedef struct packed {
		logic start;
	} scan_ctl_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

[rtl/lodd_ram.sv]
// Generic single-port RAM with registered read (read-before-write).
// No dependencies.
module lodd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/lodd_scan.sv]
// Depth-first cycle search over the lock order graph, one successor bit per cycle.
// Depends on lodd_pkg and lodd_ram (node stack); edge rows come from the top level.
module lodd_scan #(
	parameter int unsigned NUM_LOCKS = lodd_pkg::NUM_LOCKS_DEF,
	localparam int unsigned IDW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lodd_pkg::scan_ctl_t       ctl,
	input  logic [NUM_LOCKS-1:0]      reg_mask,
	input  logic [NUM_LOCKS-1:0]      row_data,
	output logic [IDW-1:0]            row_addr,
	output lodd_pkg::scan_stat_t      stat,
	output logic [lodd_pkg::ID_W-1:0] from_id,
	output logic [lodd_pkg::ID_W-1:0] to_id
);
	import lodd_pkg::*;

	localparam int unsigned CW = $clog2(NUM_LOCKS + 1);

	scan_state_t state_q, state_d;

	logic [NUM_LOCKS-1:0] visited_q, finished_q, row_q;
	logic [CW-1:0]        root_q, s_q, depth_q;
	logic [IDW-1:0]       cur_q;
	logic                 found_q;
	logic [ID_W-1:0]      from_q, to_q;

	logic [IDW-1:0] v, root_i, stk_rdata, stk_addr;
	logic           stk_we;
	logic           s_end, root_end, take, desc, back, root_go;
	logic [CW-1:0]  depth_m2;

	assign v        = s_q[IDW-1:0];
	assign root_i   = root_q[IDW-1:0];
	assign s_end    = (s_q == CW'(NUM_LOCKS));
	assign root_end = (root_q == CW'(NUM_LOCKS));
	assign take     = !s_end && row_q[v];
	assign desc     = take && !visited_q[v];
	assign back     = take && visited_q[v] && !finished_q[v];
	assign root_go  = !root_end && reg_mask[root_i] && !visited_q[root_i];
	assign depth_m2 = depth_q - CW'(2);

	// node stack: entries below depth_q hold the current DFS path
	lodd_ram #(.WIDTH(IDW), .DEPTH(NUM_LOCKS)) u_node_stk (
		.clk   (clk),
		.we    (stk_we),
		.addr  (stk_addr),
		.wdata ((state_q == SS_ROOT) ? root_i : v),
		.rdata (stk_rdata)
	);

	always_comb begin
		state_d  = state_q;
		row_addr = cur_q;
		stk_we   = 1'b0;
		stk_addr = depth_q[IDW-1:0];
		unique case (state_q)
			SS_IDLE: begin
				if (ctl.start) state_d = SS_ROOT;
			end
			SS_ROOT: begin
				row_addr = root_i;
				if (root_end) begin
					state_d = SS_DONE;
				end else if (root_go) begin
					stk_we  = 1'b1;
					state_d = SS_LOAD;
				end
			end
			SS_LOAD: state_d = SS_WALK;
			SS_WALK: begin
				if (s_end) begin
					stk_addr = depth_m2[IDW-1:0];
					state_d  = (depth_q == CW'(1)) ? SS_ROOT : SS_POP;
				end else if (desc) begin
					row_addr = v;
					stk_we   = 1'b1;
					state_d  = SS_LOAD;
				end else if (back) begin
					state_d = SS_DONE;
				end
			end
			SS_POP: begin
				row_addr = stk_rdata;
				state_d  = SS_LOAD;
			end
			SS_DONE: state_d = SS_IDLE;
			default: state_d = SS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SS_IDLE;
			visited_q  <= '0;
			finished_q <= '0;
			root_q     <= '0;
			depth_q    <= '0;
			found_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				SS_IDLE: begin
					if (ctl.start) begin
						visited_q  <= '0;
						finished_q <= '0;
						root_q     <= '0;
						depth_q    <= '0;
						found_q    <= 1'b0;
					end
				end
				SS_ROOT: begin
					if (root_go) begin
						visited_q[root_i] <= 1'b1;
						depth_q           <= CW'(1);
					end else if (!root_end) begin
						root_q <= root_q + CW'(1);
					end
				end
				SS_WALK: begin
					if (s_end) begin
						finished_q[cur_q] <= 1'b1;
						depth_q           <= depth_q - CW'(1);
						if (depth_q == CW'(1)) root_q <= root_q + CW'(1);
					end else if (desc) begin
						visited_q[v] <= 1'b1;
						depth_q      <= depth_q + CW'(1);
					end else if (back) begin
						found_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			SS_ROOT: begin
				cur_q <= root_i;
				s_q   <= '0;
			end
			SS_LOAD: row_q <= row_data;
			SS_WALK: begin
				if (!s_end && desc) begin
					cur_q <= v;
					s_q   <= '0;
				end else if (!s_end && back) begin
					from_q <= ID_W'(cur_q);
					to_q   <= ID_W'(v);
				end else if (!s_end) begin
					s_q <= s_q + CW'(1);
				end
			end
			SS_POP: begin
				// resume parent just past the child that was finished
				s_q   <= CW'(cur_q) + CW'(1);
				cur_q <= stk_rdata;
			end
			default: ;
		endcase
	end

	assign stat.done  = (state_q == SS_DONE);
	assign stat.found = found_q;
	assign from_id    = from_q;
	assign to_id      = to_q;

endmodule

[rtl/lock_order_deadlock_detector_unit.sv]
// Lock order deadlock detector. Each transaction is an acquire or release of one
// lock id and yields one result. Releases and acquires that add no new order edge
// skip the search. An acquire that adds a new edge runs a depth-first search
// through the edge RAM, one successor bit per cycle plus a row load for each node
// entered and a stack pop and row load for each node left. One transaction is
// processed at a time; the result sits in an output register and the next
// transaction may enter while it waits. Depends on lodd_pkg, lodd_ram and
// lodd_scan.
module lock_order_deadlock_detector_unit #(
	parameter int unsigned NUM_LOCKS   = lodd_pkg::NUM_LOCKS_DEF,
	parameter int unsigned STACK_DEPTH = lodd_pkg::STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [lodd_pkg::ID_W-1:0]     lock_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lodd_pkg::STATUS_W-1:0] status,
	output logic [lodd_pkg::ID_W-1:0]     cycle_from,
	output logic [lodd_pkg::ID_W-1:0]     cycle_to
);
	import lodd_pkg::*;

	localparam int unsigned IDW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int unsigned HAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(STACK_DEPTH + 1);

	top_state_t state_q, state_d;

	logic                 cmd_q;
	logic [ID_W-1:0]      id_q;
	logic [CNTW-1:0]      count_q, cnt_m1;
	logic [NUM_LOCKS-1:0] reg_mask_q, row_vld_q;
	logic                 rvld_q;
	logic [IDW-1:0]       prev_q;
	status_t              res_status_q;
	logic [ID_W-1:0]      res_from_q, res_to_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [ID_W-1:0]      out_from_q, out_to_q;

	logic [ID_W-1:0]      hs_rdata;
	logic [HAW-1:0]       hs_addr;
	logic                 hs_we;
	logic [IDW-1:0]       e_addr, scan_row_addr;
	logic                 e_we;
	logic [NUM_LOCKS-1:0] e_rdata, edge_row, id_bit;
	logic                 in_range, has_prev, is_full, push, new_pair, new_edge, out_load;
	scan_ctl_t            scan_ctl;
	scan_stat_t           scan_stat;
	logic [ID_W-1:0]      scan_from, scan_to;

	assign cnt_m1   = count_q - CNTW'(1);
	assign in_range = ({27'd0, id_q} < 32'(NUM_LOCKS));
	assign has_prev = (count_q != '0);
	assign is_full  = (count_q == CNTW'(STACK_DEPTH));
	assign id_bit   = NUM_LOCKS'(1) << IDW'(id_q);
	assign edge_row = rvld_q ? e_rdata : '0;
	assign push     = (state_q == TS_RD_TOP) && in_range && !cmd_q && !is_full;
	assign new_pair = push && has_prev && (hs_rdata != id_q);
	assign new_edge = (state_q == TS_RD_EDGE) && !edge_row[IDW'(id_q)];
	assign out_load = (state_q == TS_DONE) && (!out_valid_q || out_ready);

	assign hs_we   = push;
	assign hs_addr = (state_q == TS_RD_TOP) ? count_q[HAW-1:0] : cnt_m1[HAW-1:0];
	assign e_we    = new_edge;
	assign scan_ctl.start = new_edge;

	always_comb begin
		unique case (state_q)
			TS_SCAN:   e_addr = scan_row_addr;
			TS_RD_TOP: e_addr = IDW'(hs_rdata);
			default:   e_addr = prev_q;
		endcase
	end

	lodd_ram #(.WIDTH(ID_W), .DEPTH(STACK_DEPTH)) u_held_stk (
		.clk   (clk),
		.we    (hs_we),
		.addr  (hs_addr),
		.wdata (id_q),
		.rdata (hs_rdata)
	);

	lodd_ram #(.WIDTH(NUM_LOCKS), .DEPTH(NUM_LOCKS)) u_edges (
		.clk   (clk),
		.we    (e_we),
		.addr  (e_addr),
		.wdata (edge_row | id_bit),
		.rdata (e_rdata)
	);

	lodd_scan #(.NUM_LOCKS(NUM_LOCKS)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.reg_mask (reg_mask_q),
		.row_data (edge_row),
		.row_addr (scan_row_addr),
		.stat     (scan_stat),
		.from_id  (scan_from),
		.to_id    (scan_to)
	);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			TS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = TS_RD_TOP;
			end
			TS_RD_TOP:  state_d = new_pair ? TS_RD_EDGE : TS_DONE;
			TS_RD_EDGE: state_d = new_edge ? TS_SCAN : TS_DONE;
			TS_SCAN: begin
				if (scan_stat.done) state_d = TS_DONE;
			end
			TS_DONE: begin
				if (out_load) state_d = TS_IDLE;
			end
			default: state_d = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			count_q     <= '0;
			reg_mask_q  <= '0;
			row_vld_q   <= '0;
			rvld_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_q  <= row_vld_q[e_addr];
			if (push) begin
				count_q    <= count_q + CNTW'(1);
				reg_mask_q <= reg_mask_q | id_bit;
			end else if ((state_q == TS_RD_TOP) && in_range && cmd_q && has_prev &&
				(hs_rdata == id_q)) begin
				count_q <= cnt_m1;
			end
			if (e_we) row_vld_q[prev_q] <= 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			id_q  <= lock_id;
		end
		if (state_q == TS_RD_TOP) begin
			prev_q       <= IDW'(hs_rdata);
			res_status_q <= ST_OK;
			res_from_q   <= '0;
			res_to_q     <= '0;
			if (in_range) begin
				if (cmd_q) begin
					if (!has_prev) res_status_q <= ST_EMPTY;
					else if (hs_rdata != id_q) res_status_q <= ST_NOT_TOP;
				end else if (is_full) begin
					res_status_q <= ST_FULL;
				end
			end
		end
		if ((state_q == TS_SCAN) && scan_stat.done && scan_stat.found) begin
			res_status_q <= ST_DEADLOCK;
			res_from_q   <= scan_from;
			res_to_q     <= scan_to;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_from_q   <= res_from_q;
			out_to_q     <= res_to_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign cycle_from = out_from_q;
	assign cycle_to   = out_to_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(STACK_DEPTH))
		else $error("held count beyond stack depth");

	a_edge_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DEADLOCK) |-> (cycle_from == '0) && (cycle_to == '0))
		else $error("cycle edge reported without deadlock");

	a_busy_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TS_SCAN) |-> !in_ready)
		else $error("transaction accepted during scan");

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q != '0) && (count_q == $past(count_q) + CNTW'(1)))
		else $error("push did not advance held count");
`endif

endmodule

[verif/tb.sv]
// Testbench for lock_order_deadlock_detector_unit: directed and random lock
// acquire/release traffic, checked against a lock order graph predictor.
// Depends on lodd_pkg and the RTL of the detector.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lodd_pkg::*;

	localparam int NL = NUM_LOCKS_DEF;
	localparam int SD = STACK_DEPTH_DEF;
	localparam logic CMD_ACQ = 1'b0;
	localparam logic CMD_REL = 1'b1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		status_t     st;
		logic [4:0]  from;
		logic [4:0]  to;
	} lock_verdict_t;

	class lock_graph_board;
		logic [NL-1:0] edges [NL];
		logic [4:0]    held [SD];
		int            held_count;
		logic [NL-1:0] registered;
		logic [NL-1:0] visited, finished;
		int            order [NL];
		int            counter;
		lock_verdict_t verdicts [$];
		int            errors;

		function new();
			foreach (edges[i]) edges[i] = '0;
			foreach (held[i]) held[i] = '0;
			held_count = 0;
			registered = '0;
			errors = 0;
		endfunction

		function void discover(int id);
			visited[id] = 1'b1;
			order[id] = counter & 63;
			counter = counter + 1;
		endfunction

		// DFS over registered roots, successors in ascending id
		function bit find_cycle(output logic [4:0] f, output logic [4:0] t);
			int nstk [NL];
			int sstk [NL];
			int depth, cur, s, v;
			bit desc;
			visited = '0;
			finished = '0;
			counter = 0;
			foreach (order[i]) order[i] = 0;
			f = '0;
			t = '0;
			for (int root = 0; root < NL; root++) begin
				if (!registered[root] || visited[root]) continue;
				discover(root);
				nstk[0] = root;
				sstk[0] = 0;
				depth = 1;
				while (depth > 0) begin
					cur = nstk[depth-1];
					s = sstk[depth-1];
					desc = 0;
					while (s < NL) begin
						v = s;
						s++;
						if (!edges[cur][v]) continue;
						if (!visited[v]) begin
							sstk[depth-1] = s;
							discover(v);
							if (depth < NL) begin
								nstk[depth] = v;
								sstk[depth] = 0;
								depth++;
							end
							desc = 1;
							break;
						end
						if (order[cur] < order[v]) continue;
						if (!finished[v]) begin
							f = cur[4:0];
							t = v[4:0];
							return 1;
						end
					end
					if (!desc) begin
						finished[cur] = 1'b1;
						depth--;
					end
				end
			end
			return 0;
		endfunction

		function void note_transaction(logic cmd, logic [4:0] id);
			lock_verdict_t r;
			logic [4:0] prev;
			bit has_prev;
			r.st = ST_OK;
			r.from = '0;
			r.to = '0;
			if (cmd == CMD_ACQ) begin
				if (held_count >= SD) begin
					r.st = ST_FULL;
				end else begin
					has_prev = held_count > 0;
					prev = has_prev ? held[held_count-1] : '0;
					registered[id] = 1'b1;
					held[held_count] = id;
					held_count++;
					if (has_prev && prev != id && !edges[prev][id]) begin
						edges[prev][id] = 1'b1;
						if (find_cycle(r.from, r.to)) r.st = ST_DEADLOCK;
					end
				end
			end else begin
				if (held_count == 0) r.st = ST_EMPTY;
				else if (held[held_count-1] != id) r.st = ST_NOT_TOP;
				else held_count--;
			end
			if (r.st != ST_DEADLOCK) begin
				r.from = '0;
				r.to = '0;
			end
			verdicts.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [4:0] f, logic [4:0] t);
			lock_verdict_t e;
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected result status=%0d from=%0d to=%0d",
					$time, st, f, t);
				errors++;
				return;
			end
			e = verdicts.pop_front();
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (f !== e.from) begin
				$display("%0t: cycle_from expected %0d actual %0d", $time, e.from, f);
				errors++;
			end
			if (t !== e.to) begin
				$display("%0t: cycle_to expected %0d actual %0d", $time, e.to, t);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic [ID_W-1:0] lock_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] cycle_from, cycle_to;

	lock_graph_board sb = new();
	int phase = 0;       // 0: sender 37%, receiver 87%; 1: swapped; 2: no idling
	bit hold_req = 0;
	int quiet = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lock_order_deadlock_detector_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .lock_id(lock_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cycle_from(cycle_from), .cycle_to(cycle_to)
	);

	function automatic bit idle_roll(bit sender);
		int pct;
		if (phase == 2) return 0;
		pct = ((phase == 0) == sender) ? 37 : 87;
		return $urandom_range(99) < pct;
	endfunction

	task automatic send(logic cmd, logic [4:0] id);
		int gap;
		gap = 0;
		while (idle_roll(1) && gap < 20) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		lock_id <= id;
		do @(posedge clk); while (!in_ready);
		sb.note_transaction(cmd, id);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic random_item();
		int r;
		logic [4:0] id;
		r = $urandom_range(99);
		id = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
		if (r < 55 && sb.held_count < SD) begin
			send(CMD_ACQ, id);
		end else if (r < 88 && sb.held_count > 0) begin
			send(CMD_REL, sb.held[sb.held_count-1]);
		end else begin
			send(5'($urandom_range(1)) ? CMD_REL : CMD_ACQ, id);
		end
	endtask

	// result side
	initial begin
		int held_off;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(status, cycle_from, cycle_to);
			if (hold_req) begin
				out_ready <= 1'b0;
				held_off = 0;
				while (held_off < HOLD_CYCLES) begin
					@(posedge clk);
					held_off++;
				end
				hold_req = 0;
				out_ready <= 1'b1;
			end else begin
				out_ready <= !idle_roll(0);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty release, recursion, not-on-top, known edge, deadlock
		send(CMD_REL, 5'd0);
		send(CMD_ACQ, 5'd0);
		send(CMD_ACQ, 5'd0);
		send(CMD_REL, 5'd31);
		send(CMD_REL, 5'd0);
		send(CMD_REL, 5'd0);
		send(CMD_ACQ, 5'd31);
		send(CMD_ACQ, 5'd1);
		send(CMD_REL, 5'd1);
		send(CMD_ACQ, 5'd1);
		send(CMD_REL, 5'd1);
		send(CMD_REL, 5'd31);
		send(CMD_ACQ, 5'd1);
		send(CMD_ACQ, 5'd31);
		send(CMD_REL, 5'd31);
		send(CMD_REL, 5'd1);
		// fill the stack and push once more
		for (int i = 0; i <= SD; i++) send(CMD_ACQ, 5'd21);
		for (int i = 0; i < SD; i++) send(CMD_REL, 5'd21);
		for (int n = 0; n < 580; n++) begin
			phase = (n < 200) ? 0 : (n < 400) ? 1 : 2;
			if (n == 450) hold_req = 1;
			if (n == 500) wait_drained();
			random_item();
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.verdicts.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
